FILE: hw/rtl/isa_pkg.sv
package isa_pkg;

  // List capacity and field widths
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Per-cycle command shared by all cells of the chain
  typedef struct packed {
    logic ins;       // insert the broadcast value this cycle
    logic shift_dn;  // drain: every cell takes its upper neighbor's value
  } cell_ctl_t;

endpackage

FILE: hw/rtl/isa_cell.sv
module isa_cell (
  input  logic                             clk,
  input  isa_pkg::cell_ctl_t               ctl,
  input  logic                             occ,
  input  logic signed [isa_pkg::DATA_W-1:0] new_val,
  input  logic signed [isa_pkg::DATA_W-1:0] lo_val,
  input  logic                             lo_gt,
  input  logic signed [isa_pkg::DATA_W-1:0] hi_val,
  output logic signed [isa_pkg::DATA_W-1:0] val,
  output logic                             gt
);
  import isa_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  // Empty slots count as greater than anything, so insertion fills upward
  assign gt  = !occ || (val_r > new_val);
  assign val = val_r;

  // Greater entries move up one slot; the first greater slot takes the new value
  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_dn) begin
      val_nxt = hi_val;
    end else if (ctl.ins && gt) begin
      val_nxt = lo_gt ? lo_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: hw/rtl/insertion_sort_ascending_core.sv
// Channel | Direction | Ports                                           | Handshake
// in      | input     | in_value, in_last                               | in_valid / in_stall
// out     | output    | out_sorted_value, out_end_of_list, out_overflow | out_valid / out_stall
//
// Fill: one input beat per cycle; all cells compare against the new value in parallel
// and shift up in the same cycle.
// Drain: starts the cycle after the last beat; one result per cycle unless out_stall,
// the chain shifting down toward cell 0, which drives the output.
// in_stall is high for the whole drain; out_stall holds the current result in place.
// Reset (synchronous, rst_n low) empties the list and clears the overflow flag.
module insertion_sort_ascending_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [isa_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [isa_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_end_of_list,
  output logic                              out_overflow
);
  import isa_pkg::*;

  typedef enum logic {ST_FILL, ST_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              dropped_r, dropped_nxt;

  logic              in_acc, out_acc, full;
  cell_ctl_t         ctl;

  logic signed [DATA_W-1:0] cell_val [MAX_ITEMS];
  logic                     cell_gt  [MAX_ITEMS];

  assign full    = (count_r == CNT_W'(MAX_ITEMS));
  assign in_stall  = (state_r == ST_DRAIN);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign ctl.ins      = in_acc && !full;
  assign ctl.shift_dn = out_acc;

  // Chain of compare-and-shift cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_v, hi_v;
    logic                     lo_g;
    if (i == 0) begin : g_bot
      assign lo_v = '0;
      assign lo_g = 1'b0;
    end else begin : g_mid
      assign lo_v = cell_val[i-1];
      assign lo_g = cell_gt[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_top
      assign hi_v = '0;
    end else begin : g_nxt
      assign hi_v = cell_val[i+1];
    end
    isa_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (CNT_W'(i) < count_r),
      .new_val (in_value),
      .lo_val  (lo_v),
      .lo_gt   (lo_g),
      .hi_val  (hi_v),
      .val     (cell_val[i]),
      .gt      (cell_gt[i])
    );
  end

  // Output comes straight from the bottom cell
  assign out_sorted_value = cell_val[0];
  assign out_end_of_list  = (count_r == CNT_W'(1));
  assign out_overflow     = dropped_r;

  // Fill / drain sequencing
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt   = ST_FILL;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

FILE: hw/rtl/isa_checker.sv
module isa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [isa_pkg::DATA_W-1:0] out_sorted_value,
  input logic                              out_end_of_list,
  input logic                              out_overflow
);
  import isa_pkg::*;

  // No new input while a list is being emitted
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while results pending");

  // Last beat starts the drain on the next cycle
  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> out_valid)
    else $error("no results after last beat");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sorted_value)))
    else $error("stalled result changed");

  // Drain stops right after the end-of-list beat
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_list) |=> !out_valid)
    else $error("results continue past end of list");

  // Overflow flag is constant across one list
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_end_of_list) |=>
      (out_valid && out_overflow == $past(out_overflow)))
    else $error("overflow flag changed within a list");

endmodule

bind insertion_sort_ascending_core isa_checker u_isa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sorted_value (out_sorted_value),
  .out_end_of_list  (out_end_of_list),
  .out_overflow     (out_overflow)
);
